// ----- rtl/circular_deque_unit_defines.svh -----
// Assertion macros shared by the checker of the circular deque unit.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/cdq_pkg.sv -----
// Shared types and constants for the circular deque unit.
// No dependencies; used by every module of the block but cdq_ram.
`default_nettype none

package cdq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;   // capacity register and element count
    localparam int CAP_RESET = 16;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic {
        CS_IDLE,
        CS_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic exec;   // run the accepted operation this cycle
        logic load;   // move the result into the output register
    } cdq_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/cdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cdq_ctrl.sv -----
// Controller of the circular deque unit: input handshake, sequencing, output valid.
// Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output cdq_pkg::cdq_cmd_t      cmd
);

    cdq_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdq_pkg::CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            cdq_pkg::CS_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = cdq_pkg::CS_LOAD;
                end
            end
            cdq_pkg::CS_LOAD:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cdq_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::CS_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/cdq_datapath.sv -----
// Datapath of the circular deque unit: ring indices, element count, store, result register.
// Depends on cdq_pkg and cdq_ram.
`default_nettype none

module cdq_datapath #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cdq_pkg::cdq_cmd_t            cmd,
    input  wire logic                         cfg_wr_en,
    input  wire logic [cdq_pkg::CNT_W-1:0]    cfg_wr_data,
    input  wire logic [cdq_pkg::OP_W-1:0]     op,
    input  wire logic [DATA_WIDTH-1:0]        push_value,
    output logic      [DATA_WIDTH-1:0]        out_value,
    output logic      [cdq_pkg::STAT_W-1:0]   status,
    output logic      [cdq_pkg::CNT_W-1:0]    element_count,
    output logic                              is_empty
);

    localparam int CW     = cdq_pkg::CNT_W;
    localparam int SW     = CW + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CAP_RST = (DEPTH < cdq_pkg::CAP_RESET) ? DEPTH : cdq_pkg::CAP_RESET;

    // one compare-and-subtract suffices: every sum stays below twice the ring size
    function automatic logic [CW-1:0] wrap(input logic [SW-1:0] s, input logic [SW-1:0] c);
        logic [SW-1:0] r;
        r = (s >= c) ? (s - c) : s;
        return r[CW-1:0];
    endfunction

    logic [CW-1:0] cap_reg, front_reg, front_next, count_reg, count_next;
    logic [cdq_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic res_rd_reg, res_rd_next;

    logic [CW-1:0] cap_wr;
    logic [SW-1:0] cap6, front6, count6;
    logic [CW-1:0] idx_back_push, idx_back_last, idx_front_push, idx_front_inc;
    logic full, empty;

    logic                  ram_wr_en, ram_rd_en;
    logic [CW-1:0]         ram_wr_idx, ram_rd_idx;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    assign cap6   = {1'b0, cap_reg};
    assign front6 = {1'b0, front_reg};
    assign count6 = {1'b0, count_reg};

    assign idx_back_push  = wrap(front6 + count6, cap6);
    assign idx_back_last  = wrap(front6 + count6 - SW'(1), cap6);
    assign idx_front_push = wrap(front6 + cap6 - SW'(1), cap6);
    assign idx_front_inc  = wrap(front6 + SW'(1), cap6);

    assign full  = (count_reg >= cap_reg);
    assign empty = (count_reg == '0);

    // clamp the written capacity to 1..DEPTH
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            cap_wr = CW'(1);
        end
        else if (int'(cfg_wr_data) > DEPTH)
        begin
            cap_wr = CW'(DEPTH);
        end
        else
        begin
            cap_wr = cfg_wr_data;
        end
    end

    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        res_status_next = cdq_pkg::ST_OK;
        res_rd_next     = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_idx      = idx_back_push;
        ram_rd_en       = 1'b0;
        ram_rd_idx      = front_reg;
        unique case (op)
            cdq_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    res_status_next = cdq_pkg::ST_FULL;
                end
                else
                begin
                    ram_wr_en  = 1'b1;
                    ram_wr_idx = idx_front_push;
                    front_next = idx_front_push;
                    count_next = count_reg + CW'(1);
                end
            end
            cdq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    res_status_next = cdq_pkg::ST_FULL;
                end
                else
                begin
                    ram_wr_en  = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            cdq_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    res_status_next = cdq_pkg::ST_EMPTY;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    res_rd_next = 1'b1;
                    front_next  = idx_front_inc;
                    count_next  = count_reg - CW'(1);
                end
            end
            cdq_pkg::OP_POP_BACK:
            begin
                if (empty)
                begin
                    res_status_next = cdq_pkg::ST_EMPTY;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_idx  = idx_back_last;
                    res_rd_next = 1'b1;
                    count_next  = count_reg - CW'(1);
                end
            end
            cdq_pkg::OP_PEEK_FRONT:
            begin
                if (empty)
                begin
                    res_status_next = cdq_pkg::ST_EMPTY;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    res_rd_next = 1'b1;
                end
            end
            cdq_pkg::OP_PEEK_BACK:
            begin
                if (empty)
                begin
                    res_status_next = cdq_pkg::ST_EMPTY;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_idx  = idx_back_last;
                    res_rd_next = 1'b1;
                end
            end
            default:
            begin
                res_status_next = cdq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CW'(CAP_RST);
            front_reg      <= '0;
            count_reg      <= '0;
            res_status_reg <= cdq_pkg::ST_OK;
            res_rd_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            // a capacity write also empties the queue
            cap_reg   <= cap_wr;
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg      <= front_next;
            count_reg      <= count_next;
            res_status_reg <= res_status_next;
            res_rd_reg     <= res_rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_value     <= res_rd_reg ? ram_rd_data : '0;
            status        <= res_status_reg;
            element_count <= count_reg;
            is_empty      <= (count_reg == '0);
        end
    end

    cdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.exec && ram_wr_en),
        .wr_addr (ADDR_W'(ram_wr_idx)),
        .wr_data (push_value),
        .rd_en   (cmd.exec && ram_rd_en),
        .rd_addr (ADDR_W'(ram_rd_idx)),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ----- rtl/circular_deque_unit.sv -----
// Circular deque unit: the store is accessed at the input accept edge (state CS_IDLE) and
// the result is loaded into the output register from state CS_LOAD once that register is
// free; m_tvalid rises with the load. No new item is taken until that load, but the
// input side takes an item while a previous result still waits in the output register.
// Reset (rst_n low, asynchronous) empties the queue and sets the ring size to the smaller
// of DEPTH and 16; store contents are not cleared and need no clearing pass.
`default_nettype none

module circular_deque_unit #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
    localparam int IN_W  = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_RAW_W = DATA_WIDTH + cdq_pkg::STAT_W + cdq_pkg::CNT_W + 1,
    localparam int OUT_W = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration: ring size in use, 1..DEPTH after clamping
    input  wire logic                          cfg_wr_en,
    input  wire logic [cdq_pkg::CNT_W-1:0]     cfg_wr_data,
    // input items
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [IN_W-1:0]               s_tdata,   // push_value, zero fill
    input  wire logic [cdq_pkg::OP_W-1:0]      s_tuser,   // op
    // result items
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [OUT_W-1:0]              m_tdata    // out_value, status,
                                                          // element_count, is_empty,
                                                          // zero fill
);

    cdq_pkg::cdq_cmd_t cmd;

    logic [DATA_WIDTH-1:0]          out_value;
    logic [cdq_pkg::STAT_W-1:0]     status;
    logic [cdq_pkg::CNT_W-1:0]      element_count;
    logic                           is_empty;

    // Controller: accept one item, then wait for room in the output register.
    cdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Datapath: ring index arithmetic, count, store access and result register.
    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .op            (s_tuser),
        .push_value    (s_tdata[DATA_WIDTH-1:0]),
        .out_value     (out_value),
        .status        (status),
        .element_count (element_count),
        .is_empty      (is_empty)
    );

    // Pack the result fields, lowest first, zero fill to whole bytes.
    assign m_tdata = OUT_W'({is_empty, element_count, status, out_value});

endmodule

`default_nettype wire

// ----- rtl/cdq_checker.sv -----
// Port-level checker for the circular deque unit, bound to its top level.
// Depends on cdq_pkg and circular_deque_unit_defines.svh.
`default_nettype none
`include "circular_deque_unit_defines.svh"

module cdq_checker #(
    parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
    localparam int IN_W  = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_RAW_W = DATA_WIDTH + cdq_pkg::STAT_W + cdq_pkg::CNT_W + 1,
    localparam int OUT_W = ((OUT_RAW_W + 7) / 8) * 8,
    localparam int ST_LO = DATA_WIDTH,
    localparam int CN_LO = DATA_WIDTH + cdq_pkg::STAT_W,
    localparam int EM_B  = CN_LO + cdq_pkg::CNT_W
) (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       cfg_wr_en,
    input wire logic [cdq_pkg::CNT_W-1:0]  cfg_wr_data,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic [IN_W-1:0]            s_tdata,
    input wire logic [cdq_pkg::OP_W-1:0]   s_tuser,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [OUT_W-1:0]           m_tdata
);

    logic [DATA_WIDTH-1:0]      chk_value;
    logic [cdq_pkg::STAT_W-1:0] chk_status;
    logic [cdq_pkg::CNT_W-1:0]  chk_count;
    logic                       chk_empty;
    logic                       chk_unused;

    assign chk_value  = m_tdata[DATA_WIDTH-1:0];
    assign chk_status = m_tdata[CN_LO-1:ST_LO];
    assign chk_count  = m_tdata[EM_B-1:CN_LO];
    assign chk_empty  = m_tdata[EM_B];
    assign chk_unused = cfg_wr_en ^ (^cfg_wr_data) ^ (^s_tdata) ^ (^s_tuser);

    `CDQ_ASSERT_NEXT(a_valid_holds, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `CDQ_ASSERT_NEXT(a_data_holds, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `CDQ_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `CDQ_ASSERT_IMPL(a_empty_flag, clk, rst_n, m_tvalid, chk_empty == (chk_count == '0))
    `CDQ_ASSERT_IMPL(a_reject_zero, clk, rst_n, m_tvalid && (chk_status == cdq_pkg::ST_EMPTY || chk_status == cdq_pkg::ST_FULL), (chk_value == '0) || chk_unused)

endmodule

bind circular_deque_unit cdq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cdq_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for circular_deque_unit: drives deque operations over the
// input stream, predicts every result item and checks it against the output stream.
// Depends on cdq_pkg (op and status codes, field widths) and the circular_deque_unit RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = cdq_pkg::DEPTH_DEF;
    localparam int VAL_W      = cdq_pkg::DATA_WIDTH_DEF;
    localparam int OP_W       = cdq_pkg::OP_W;
    localparam int STAT_W     = cdq_pkg::STAT_W;
    localparam int CNT_W      = cdq_pkg::CNT_W;
    localparam int OUT_BYTES_W = ((VAL_W + STAT_W + CNT_W + 1 + 7) / 8) * 8;

    // Op codes the block must treat as no-ops.
    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

    // Bias of a stretch of random operations.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } op_mix_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
    } deque_op_t;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic              empty;
    } deque_result_t;

    // Block ports; every input is known from time zero.
    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [VAL_W-1:0]       s_tdata     = '0;   // push_value
    logic [OP_W-1:0]        s_tuser     = '0;   // op
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_BYTES_W-1:0] m_tdata;            // out_value, status, element_count,
                                                // is_empty, zero fill

    // Stimulus and scoreboard.
    deque_op_t     queued_ops[$];
    deque_result_t awaited_results[$];
    logic          quiet_run = 1'b0;     // no idling on either side while set
    int            mismatches = 0;
    int            ops_accepted = 0;
    int            results_checked = 0;
    int            full_drops = 0;
    int            empty_rejects = 0;
    int            cap_writes = 0;

    // Predictor state: a private copy of the ring, its head and its fill.
    logic [VAL_W-1:0] ring [RING_DEPTH];
    int               head = 0;
    int               held = 0;
    logic [CNT_W-1:0] ring_cap = CNT_W'(cdq_pkg::CAP_RESET);

    circular_deque_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reduce an index below the ring size by compare and subtract.
    function automatic int ring_wrap(input int idx, input int cap);
        int i;
        i = idx;
        while (i >= cap)
            i = i - cap;
        if (i >= RING_DEPTH)
            i = 0;
        return i;
    endfunction

    // Apply one operation to the predicted deque and return the result it gives.
    function automatic deque_result_t deque_apply(input logic [OP_W-1:0] op,
                                                  input logic [VAL_W-1:0] value);
        deque_result_t r;
        int            cap;
        int            pos;
        r.value  = '0;
        r.status = cdq_pkg::ST_OK;
        // A size of zero acts as one, anything past the store acts as the full store.
        cap = (ring_cap == 0) ? 1 : ((int'(ring_cap) > RING_DEPTH) ? RING_DEPTH : ring_cap);
        case (op) inside
            cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK:
            begin
                if (held >= cap)
                begin
                    // Full: drop the element, keep the state.
                    r.status = cdq_pkg::ST_FULL;
                    full_drops++;
                end
                else if (op == cdq_pkg::OP_PUSH_FRONT)
                begin
                    head = ring_wrap(head + cap - 1, cap);
                    ring[head] = value;
                    held++;
                end
                else
                begin
                    ring[ring_wrap(head + held, cap)] = value;
                    held++;
                end
            end
            cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK,
            cdq_pkg::OP_PEEK_FRONT, cdq_pkg::OP_PEEK_BACK:
            begin
                if (held == 0)
                begin
                    // Empty: reject, return zero, keep the state.
                    r.status = cdq_pkg::ST_EMPTY;
                    empty_rejects++;
                end
                else
                begin
                    if (op == cdq_pkg::OP_POP_FRONT || op == cdq_pkg::OP_PEEK_FRONT)
                        pos = ring_wrap(head, cap);
                    else
                        pos = ring_wrap(head + held - 1, cap);
                    r.value = ring[pos];
                    if (op == cdq_pkg::OP_POP_FRONT)
                    begin
                        head = ring_wrap(head + 1, cap);
                        held--;
                    end
                    else if (op == cdq_pkg::OP_POP_BACK)
                        held--;
                end
            end
            default: ;   // unused codes change nothing
        endcase
        r.count = held[CNT_W-1:0];
        r.empty = (held == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("%0t ns: MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
                 $time, what, got, want, results_checked);
        mismatches++;
    endtask

    // Driver: present queued operations; on each accept, predict the result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_results.push_back(deque_apply(s_tuser, s_tdata));
                ops_accepted++;
            end
            // Load the next item once the current one is gone; hold otherwise.
            if (!s_tvalid || s_tready)
            begin
                if (queued_ops.size() > 0 && (quiet_run || $urandom_range(0, 99) >= 25))
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= queued_ops[0].op;
                    s_tdata  <= queued_ops[0].value;
                    void'(queued_ops.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and check each accepted result against the oldest
    // prediction, field by field.
    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("unexpected result item", m_tdata[VAL_W-1:0], '0);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_tdata[VAL_W-1:0] !== want.value)
                        report_mismatch("out_value", m_tdata[VAL_W-1:0], want.value);
                    if (m_tdata[VAL_W +: STAT_W] !== want.status)
                        report_mismatch("status", VAL_W'(m_tdata[VAL_W +: STAT_W]),
                                        VAL_W'(want.status));
                    if (m_tdata[VAL_W+STAT_W +: CNT_W] !== want.count)
                        report_mismatch("element_count",
                                        VAL_W'(m_tdata[VAL_W+STAT_W +: CNT_W]),
                                        VAL_W'(want.count));
                    if (m_tdata[VAL_W+STAT_W+CNT_W] !== want.empty)
                        report_mismatch("is_empty", VAL_W'(m_tdata[VAL_W+STAT_W+CNT_W]),
                                        VAL_W'(want.empty));
                end
                results_checked++;
            end
            m_tready <= quiet_run || ($urandom_range(0, 99) >= 25);
        end
    end

    task automatic add_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
        deque_op_t item;
        item.op    = op;
        item.value = value;
        queued_ops.push_back(item);
    endtask

    // Hold until every item is sent and every result is back, then let the
    // pipeline drain.
    task automatic wait_idle();
        while (queued_ops.size() > 0 || s_tvalid || awaited_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the ring size; the block empties the deque on any write.
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        wait_idle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        ring_cap = cap;
        head     = 0;
        held     = 0;
        cap_writes++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Element value: mostly random, often the extremes.
    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 32'h8000_0000;
        else if (roll < 20)
            return 32'h7fff_ffff;
        else if (roll < 25)
            return '0;
        else if (roll < 30)
            return '1;
        return $urandom;
    endfunction

    // One random operation, weighted by the current mix.
    task automatic add_random_op(input op_mix_t mix);
        int roll;
        int push_lim;
        int pop_lim;
        logic [OP_W-1:0] op;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin push_lim = 70; pop_lim = 85; end
            MIX_DRAIN: begin push_lim = 25; pop_lim = 75; end
            default:   begin push_lim = 48; pop_lim = 83; end
        endcase
        if (roll < 3)
            op = ($urandom_range(0, 1) == 0) ? OP_RSVD_LO : OP_RSVD_HI;
        else if (roll < push_lim)
            op = ($urandom_range(0, 1) == 0) ? cdq_pkg::OP_PUSH_FRONT
                                             : cdq_pkg::OP_PUSH_BACK;
        else if (roll < pop_lim)
            op = ($urandom_range(0, 1) == 0) ? cdq_pkg::OP_POP_FRONT
                                             : cdq_pkg::OP_POP_BACK;
        else
            op = ($urandom_range(0, 1) == 0) ? cdq_pkg::OP_PEEK_FRONT
                                             : cdq_pkg::OP_PEEK_BACK;
        // Non-push items carry random data that the block must ignore.
        add_op(op, pick_value());
    endtask

    // Stimulus sequence.
    initial
    begin
        logic [CNT_W-1:0] phase_caps [12];
        op_mix_t          mix;
        phase_caps = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd3, 5'd16, 5'd5,
                       5'd9, 5'd16, 5'd0, 5'd0};
        phase_caps[10] = CNT_W'($urandom_range(0, 31));
        phase_caps[11] = CNT_W'($urandom_range(1, 16));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at the reset size of 16: every op on an empty deque, the
        // field extremes, unused codes, and draining back to empty.
        add_op(cdq_pkg::OP_PEEK_FRONT, 32'hdead_beef);
        add_op(cdq_pkg::OP_POP_BACK,   '0);
        add_op(cdq_pkg::OP_POP_FRONT,  '1);
        add_op(cdq_pkg::OP_PEEK_BACK,  '0);
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
        add_op(cdq_pkg::OP_PUSH_BACK,  32'h8000_0000);
        add_op(cdq_pkg::OP_PUSH_FRONT, '0);
        add_op(cdq_pkg::OP_PUSH_BACK,  '1);
        add_op(cdq_pkg::OP_PEEK_FRONT, '0);
        add_op(cdq_pkg::OP_PEEK_BACK,  '0);
        add_op(OP_RSVD_LO,             32'h1234_5678);
        add_op(OP_RSVD_HI,             '1);
        add_op(cdq_pkg::OP_POP_FRONT,  '0);
        add_op(cdq_pkg::OP_POP_BACK,   '0);
        add_op(cdq_pkg::OP_POP_BACK,   '0);
        add_op(cdq_pkg::OP_POP_FRONT,  '0);
        add_op(cdq_pkg::OP_POP_FRONT,  '0);

        // Directed, ring of one: push into a full deque, then empty it.
        write_capacity(5'd1);
        add_op(cdq_pkg::OP_PUSH_BACK,  32'h0000_00a5);
        add_op(cdq_pkg::OP_PUSH_FRONT, 32'h5a5a_5a5a);
        add_op(cdq_pkg::OP_PUSH_BACK,  32'hffff_0000);
        add_op(cdq_pkg::OP_PEEK_BACK,  '0);
        add_op(cdq_pkg::OP_POP_BACK,   '0);
        add_op(cdq_pkg::OP_PEEK_FRONT, '0);

        // Random phases, one ring size each, including out-of-range sizes.
        foreach (phase_caps[p])
        begin
            write_capacity(phase_caps[p]);
            quiet_run = (p == 6);
            for (int n = 0; n < 110; n++)
            begin
                // Switch the mix every 30 items so the deque swings full and empty.
                if (n % 30 == 0)
                    mix = op_mix_t'($urandom_range(0, 2));
                add_random_op(mix);
            end
        end

        wait_idle();
        quiet_run = 1'b0;
        repeat (8) @(posedge clk);
        $display("Covered %0d operations over %0d ring size writes; %0d results checked.",
                 ops_accepted, cap_writes, results_checked);
        $display("Pushes dropped full: %0d, pops/peeks rejected empty: %0d, mismatches: %0d.",
                 full_drops, empty_rejects, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: end a hung run.
    initial
    begin
        #3_000_000;
        $display("Timeout with %0d results still awaited", awaited_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
